// ===== hw/rtl/ckhc_pkg.sv =====
// shared types, constants and the baseline tuning function for the
// capacitive key hysteresis calibrator; no dependencies
package ckhc_pkg;

	// default matrix size
	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 16;

	// field and register widths
	localparam int ROW_W   = 3;
	localparam int COL_W   = 4;
	localparam int VALUE_W = 12;
	localparam int BASE_W  = 16;
	localparam int OFS_W   = 12;
	localparam int CEIL_W  = 13;
	localparam int CNT_W   = 17;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;

	// register reset values
	localparam logic [OFS_W-1:0]   ACT_OFS_RST   = 12'd70;
	localparam logic [OFS_W-1:0]   REL_OFS_RST   = 12'd55;
	localparam logic [OFS_W-1:0]   IDLE_RST      = 12'd550;
	localparam logic [CEIL_W-1:0]  CEIL_RST      = 13'd620;
	localparam logic [CNT_W-1:0]   CAL_CNT_RST   = 17'd100000;
	localparam logic [BASE_W-1:0]  BASE_RST      = 16'd550;

	// floor((s - b + 25) / 50) is taken as floor(u / 50) - TUNE_OFS with
	// u = s - b + 25 + 50 * TUNE_OFS kept positive; u / 50 = (u >> 1) / 25,
	// and the divide by 25 is a multiply by ceil(2^21 / 25) and a shift
	localparam logic [CNT_W-1:0]   TUNE_BIAS   = 17'd65575;
	localparam logic [BASE_W-1:0]  TUNE_OFS    = 16'd1311;
	localparam logic [16:0]        TUNE_RECIP  = 17'd83887;
	localparam int                 TUNE_SHIFT  = 21;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	// register index, byte address divided by four
	typedef enum logic [2:0] {
		REG_ACT_OFS   = 3'd0,
		REG_REL_OFS   = 3'd1,
		REG_IDLE      = 3'd2,
		REG_CEIL      = 3'd3,
		REG_CAL_CNT   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		op_t               op;
		logic [ROW_W-1:0]   key_row;
		logic [COL_W-1:0]   key_col;
		logic [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic pressed;
		logic changed;
		logic calibrated;
		logic calibration_done;
	} out_item_t;

	// one key memory word
	typedef struct packed {
		logic              press;
		logic [BASE_W-1:0] base;
	} key_entry_t;

	// move base toward sample by floor((sample - base + 25) / 50)
	function automatic logic [BASE_W-1:0] tune_toward(input logic [BASE_W-1:0] base,
			input logic [VALUE_W-1:0] sample);
		logic [CNT_W-1:0]  u;
		logic [15:0]       y;
		logic [32:0]       prod;
		logic [BASE_W-1:0] q;
		u    = CNT_W'(sample) + TUNE_BIAS - CNT_W'(base);
		y    = u[CNT_W-1:1];
		prod = 33'(y) * 33'(TUNE_RECIP);
		q    = BASE_W'(prod[32:TUNE_SHIFT]);
		return base + q - TUNE_OFS;
	endfunction

endpackage

// ===== hw/rtl/capacitive_key_hysteresis_calibrator.sv =====
// top level of the capacitive key hysteresis calibrator: key memory,
// press decision, baseline tuning, calibration count and register port
// depends on ckhc_pkg
//
// Each item carries one ADC sample or one stored baseline for a key of a
// ROWS x COLS matrix. The block takes one item per clock unless a full
// output register that is not taken holds stage 1 or the clearing pass
// runs. An item goes through the stage 1 register and then the output
// register, which drives result_valid. A new item is taken while a result
// waits in the output register as long as stage 1 is free. Per-key press
// bits and baselines live in one memory with a registered read; the last
// write is forwarded to the next item so that back-to-back items on the
// same key see fresh data. After reset the block clears the memory, one
// key per cycle, before sample_ready rises; register writes are taken
// during that time. Registers sit at byte addresses 0, 4, 8, 12 and 16 and
// should be written only while no item is in flight.
module capacitive_key_hysteresis_calibrator #(
	parameter int ROWS = ckhc_pkg::ROWS_DEF,
	parameter int COLS = ckhc_pkg::COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  ckhc_pkg::in_item_t            sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output ckhc_pkg::out_item_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ckhc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ckhc_pkg::DATA_W-1:0]   pwdata,
	output logic [ckhc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int KEYS  = ROWS * COLS;
	localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

	// configuration registers
	logic [ckhc_pkg::OFS_W-1:0]  act_ofs_q;
	logic [ckhc_pkg::OFS_W-1:0]  rel_ofs_q;
	logic [ckhc_pkg::OFS_W-1:0]  idle_q;
	logic [ckhc_pkg::CEIL_W-1:0] ceil_q;
	logic [ckhc_pkg::CNT_W-1:0]  cal_cnt_q;
	logic                        cfg_we;
	ckhc_pkg::reg_idx_t          reg_sel;

	// calibration state
	logic [ckhc_pkg::CNT_W-1:0]  samples_left_q;
	logic                        calibrated_q;

	// clearing pass
	logic                        clearing_q;
	logic [IDX_W-1:0]            clr_idx_q;

	// key memory
	ckhc_pkg::key_entry_t        key_mem [KEYS];
	ckhc_pkg::key_entry_t        rdata_q;
	ckhc_pkg::key_entry_t        wdata;
	logic [IDX_W-1:0]            waddr;
	logic                        we;
	logic                        re;

	// forwarding of the last item write
	logic                        fwd_valid_q;
	logic [IDX_W-1:0]            fwd_idx_q;
	ckhc_pkg::key_entry_t        fwd_data_q;

	// input side
	logic                        accept;
	logic [IDX_W-1:0]            in_idx;
	logic                        in_hit;

	// stage 1
	logic                        s1_valid_q;
	ckhc_pkg::in_item_t          item_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic                        hit_s1;
	logic                        s1_fire;
	ckhc_pkg::key_entry_t        rd_entry;
	ckhc_pkg::key_entry_t        new_entry;
	logic [ckhc_pkg::BASE_W-1:0] base_sel;
	logic [ckhc_pkg::CNT_W-1:0]  rel_thr;
	logic [ckhc_pkg::CNT_W-1:0]  act_thr;
	logic [ckhc_pkg::BASE_W-1:0] tuned;
	logic [ckhc_pkg::CNT_W-1:0]  sl_dec;
	logic [ckhc_pkg::CNT_W-1:0]  sl_next;
	logic                        cal_next;
	logic                        new_press;
	logic                        chg;
	logic                        done;
	ckhc_pkg::out_item_t         res;

	// output register
	logic                        out_valid_q;
	ckhc_pkg::out_item_t         result_q;

	// register port
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign reg_sel = ckhc_pkg::reg_idx_t'(paddr[ckhc_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_ofs_q <= ckhc_pkg::ACT_OFS_RST;
			rel_ofs_q <= ckhc_pkg::REL_OFS_RST;
			idle_q    <= ckhc_pkg::IDLE_RST;
			ceil_q    <= ckhc_pkg::CEIL_RST;
			cal_cnt_q <= ckhc_pkg::CAL_CNT_RST;
		end else if (cfg_we) begin
			case (reg_sel)
				ckhc_pkg::REG_ACT_OFS: act_ofs_q <= pwdata[ckhc_pkg::OFS_W-1:0];
				ckhc_pkg::REG_REL_OFS: rel_ofs_q <= pwdata[ckhc_pkg::OFS_W-1:0];
				ckhc_pkg::REG_IDLE:    idle_q    <= pwdata[ckhc_pkg::OFS_W-1:0];
				ckhc_pkg::REG_CEIL:    ceil_q    <= pwdata[ckhc_pkg::CEIL_W-1:0];
				ckhc_pkg::REG_CAL_CNT: cal_cnt_q <= pwdata[ckhc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_sel)
			ckhc_pkg::REG_ACT_OFS: prdata = ckhc_pkg::DATA_W'(act_ofs_q);
			ckhc_pkg::REG_REL_OFS: prdata = ckhc_pkg::DATA_W'(rel_ofs_q);
			ckhc_pkg::REG_IDLE:    prdata = ckhc_pkg::DATA_W'(idle_q);
			ckhc_pkg::REG_CEIL:    prdata = ckhc_pkg::DATA_W'(ceil_q);
			ckhc_pkg::REG_CAL_CNT: prdata = ckhc_pkg::DATA_W'(cal_cnt_q);
			default:               prdata = '0;
		endcase
	end

	// clearing pass over the key memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == IDX_W'(KEYS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end

	// input handshake and key index
	assign s1_fire      = s1_valid_q & (~out_valid_q | result_ready);
	assign sample_ready = ~clearing_q & (~s1_valid_q | s1_fire);
	assign accept       = sample_valid & sample_ready;
	assign in_hit       = (int'(sample.key_row) < ROWS) && (int'(sample.key_col) < COLS);
	assign in_idx       = IDX_W'(int'(sample.key_row) * COLS + int'(sample.key_col));
	assign re           = accept & in_hit;

	// stage 1 item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
			idx_s1  <= in_idx;
			hit_s1  <= in_hit;
		end
	end

	// key memory write port: clearing pass or item write-back
	always_comb begin
		if (clearing_q) begin
			we         = 1'b1;
			waddr      = clr_idx_q;
			wdata.press = 1'b0;
			wdata.base  = ckhc_pkg::BASE_RST;
		end else begin
			we    = s1_fire & hit_s1;
			waddr = idx_s1;
			wdata = new_entry;
		end
	end

	// key memory, read-first with registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= key_mem[in_idx];
		end
	end

	// last write, forwarded to an item that read the same key in that cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_fire && hit_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && hit_s1) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= new_entry;
		end
	end

	assign rd_entry = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : rdata_q;

	// thresholds and tuned baseline
	assign base_sel = calibrated_q ? rd_entry.base : ckhc_pkg::BASE_W'(idle_q);
	assign rel_thr  = ckhc_pkg::CNT_W'(base_sel) + ckhc_pkg::CNT_W'(rel_ofs_q);
	assign act_thr  = ckhc_pkg::CNT_W'(base_sel) + ckhc_pkg::CNT_W'(act_ofs_q);
	assign tuned    = ckhc_pkg::tune_toward(rd_entry.base, item_s1.value);
	assign sl_dec   = (samples_left_q != '0) ? samples_left_q - ckhc_pkg::CNT_W'(1) : '0;

	// press decision, calibration step and write-back word
	always_comb begin
		new_press = rd_entry.press;
		chg       = 1'b0;
		done      = 1'b0;
		cal_next  = calibrated_q;
		sl_next   = samples_left_q;
		new_entry = rd_entry;
		if (hit_s1) begin
			case (item_s1.op)
				ckhc_pkg::OP_LOAD: begin
					new_entry.base = ckhc_pkg::BASE_W'(item_s1.value);
					cal_next       = 1'b1;
				end
				ckhc_pkg::OP_SAMPLE: begin
					if (rd_entry.press && ckhc_pkg::CNT_W'(item_s1.value) < rel_thr) begin
						new_press = 1'b0;
						chg       = 1'b1;
					end else if (!rd_entry.press
							&& ckhc_pkg::CNT_W'(item_s1.value) > act_thr) begin
						new_press = 1'b1;
						chg       = 1'b1;
					end
					new_entry.press = new_press;
					if (!calibrated_q) begin
						sl_next = sl_dec;
						if (ckhc_pkg::CEIL_W'(item_s1.value) < ceil_q) begin
							new_entry.base = tuned;
						end
						if (sl_dec == '0) begin
							cal_next = 1'b1;
							done     = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		res.pressed          = hit_s1 & new_press;
		res.changed          = chg;
		res.calibrated       = cal_next;
		res.calibration_done = done;
	end

	// calibration count and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_left_q <= ckhc_pkg::CAL_CNT_RST;
			calibrated_q   <= 1'b0;
		end else if (cfg_we && reg_sel == ckhc_pkg::REG_CAL_CNT) begin
			samples_left_q <= pwdata[ckhc_pkg::CNT_W-1:0];
		end else if (s1_fire) begin
			samples_left_q <= sl_next;
			calibrated_q   <= cal_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			result_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	// the block never leaves the calibrated state except by reset
	assert property (@(posedge clk) disable iff (!arst_n) !$fell(calibrated_q))
		else $error("calibrated flag dropped");

	// a completing sample reports calibrated and leaves the count at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.calibration_done |->
			result.calibrated && samples_left_q == '0)
		else $error("calibration done without calibrated state");

	// without a register write the count moves down by at most one per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> samples_left_q == $past(samples_left_q)
			|| samples_left_q == $past(samples_left_q) - 17'd1)
		else $error("sample count jumped");

endmodule
